// ----- hdl/ndd_pkg.sv -----
// ============================================================================
// ndd_pkg: shared types and constants for the divided-difference interpolator
// Holds the controller/datapath command and status structs and Q16.16 limits.
// ============================================================================
package ndd_pkg;

    localparam int unsigned NDD_MAX_POINTS = 16;
    localparam int unsigned RESULT_LIMIT   = 16;
    localparam int unsigned QW             = 32;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic signed [31:0] Q_ONE = 32'sh00010000;

    typedef enum logic [3:0] {
        DOP_NONE   = 4'd0,
        DOP_DIV    = 4'd1,
        DOP_XTERM  = 4'd2,
        DOP_TERM   = 4'd3,
        DOP_FIRST  = 4'd4
    } dp_op_t;

    typedef struct packed {
        logic   start;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic zero_den;
    } dp_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        if (v > 41'sh0007fffffff) begin
            return Q_MAX;
        end else if (v < -41'sh00080000000) begin
            return Q_MIN;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [31:0] signed_from(input logic [63:0] m,
                                                       input logic neg);
        logic [32:0] lim;
        lim = (m > 64'h7fffffff) ? 33'h080000000 : {1'b0, m[31:0]};
        if (neg) begin
            return (lim >= 33'h080000000) ? Q_MIN : -$signed(lim[31:0]);
        end else begin
            return (lim >= 33'h080000000) ? Q_MAX : $signed(lim[31:0]);
        end
    endfunction

endpackage

// ----- hdl/ndd_ram.sv -----
// ============================================================================
// ndd_ram: generic single-port-write, registered-read RAM
// One write port, one read port, read data registered.
// ============================================================================
module ndd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/ndd_datapath.sv -----
// ============================================================================
// ndd_datapath: arithmetic unit of the interpolator
// Serial restoring divider for the divided differences and a two-step
// multiplier for the Newton form evaluation.
// ============================================================================
module ndd_datapath
    import ndd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    input  logic signed [31:0] opa_hi,   // numerator minuend / xterm
    input  logic signed [31:0] opa_lo,   // numerator subtrahend / query
    input  logic signed [31:0] opb_hi,   // denominator minuend / abscissa / previous estimate
    input  logic signed [31:0] opb_lo,   // denominator subtrahend / coef
    output dp_sts_t            sts,
    output logic signed [31:0] result
);

    // divider, multiplier and result state
    logic [48:0] rem_reg, rem_next;
    logic [48:0] num_reg, num_next;
    logic [32:0] den_reg, den_next;
    logic [48:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        zden_reg, zden_next;
    logic [1:0]  mstep_reg, mstep_next;
    logic [63:0] prod_reg, prod_next;
    logic signed [31:0] res_reg, res_next;
    dp_op_t      op_reg, op_next;

    logic signed [32:0] n33, d33;
    logic [32:0]        un, ud;
    logic [49:0]        trial;
    logic [48:0]        shifted;
    logic [31:0]        ma, mb;
    logic [63:0]        rnd;
    logic signed [40:0] sum41;

    assign n33 = 33'(opa_hi) - 33'(opa_lo);
    assign d33 = 33'(opb_hi) - 33'(opb_lo);
    assign un  = n33[32] ? 33'(-n33) : 33'(n33);
    assign ud  = d33[32] ? 33'(-d33) : 33'(d33);

    // Multiply operands: xterm step uses sat(query - x), term step uses coef.
    assign ma  = opa_hi[31] ? 32'(-opa_hi) : 32'(opa_hi);
    always_comb begin
        logic signed [32:0] dq;
        logic signed [31:0] s;
        dq = 33'(opa_lo) - 33'(opb_hi);
        s  = sat32(41'(dq));
        if (op_reg == DOP_XTERM) begin
            mb = s[31] ? 32'(-s) : 32'(s);
        end else begin
            mb = opb_lo[31] ? 32'(-opb_lo) : 32'(opb_lo);
        end
    end
    assign rnd = (prod_reg + 64'd32768) >> 16;

    assign shifted = {rem_reg[47:0], num_reg[48]};
    assign trial   = {1'b0, shifted} - {17'd0, den_reg};
    assign sum41   = 41'(opb_hi) + 41'(signed_from(rnd, neg_reg));

    always_comb begin
        rem_next   = rem_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        busy_next  = busy_reg;
        zden_next  = 1'b0;
        mstep_next = mstep_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        op_next    = op_reg;
        if (cmd.start) begin
            op_next   = cmd.op;
            busy_next = 1'b1;
            case (cmd.op)
                DOP_DIV: begin
                    if (ud == 33'd0) begin
                        res_next  = '0;
                        zden_next = 1'b1;
                        busy_next = 1'b0;
                    end else begin
                        // numerator scaled by 2^16 plus half the divisor
                        num_next = {un, 16'd0} + 49'(ud >> 1);
                        den_next = ud;
                        rem_next = '0;
                        quo_next = '0;
                        cnt_next = 6'd49;
                        neg_next = n33[32] ^ d33[32];
                    end
                end
                DOP_XTERM, DOP_TERM: begin
                    mstep_next = 2'd1;
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end else if (busy_reg) begin
            case (op_reg)
                DOP_DIV: begin
                    if (!trial[49]) begin
                        rem_next = trial[48:0];
                        quo_next = {quo_reg[47:0], 1'b1};
                    end else begin
                        rem_next = shifted;
                        quo_next = {quo_reg[47:0], 1'b0};
                    end
                    num_next = {num_reg[47:0], 1'b0};
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        busy_next = 1'b0;
                        res_next  = signed_from(64'(quo_next), neg_reg);
                    end
                end
                DOP_XTERM, DOP_TERM: begin
                    if (mstep_reg == 2'd1) begin
                        prod_next  = 64'(ma) * 64'(mb);
                        neg_next   = (opa_hi[31] ^ ((op_reg == DOP_XTERM)
                                     ? (opa_lo < opb_hi) : opb_lo[31]))
                                     && (ma != 0) && (mb != 0);
                        mstep_next = 2'd2;
                    end else begin
                        if (op_reg == DOP_XTERM) begin
                            res_next = signed_from(rnd, neg_reg);
                        end else begin
                            res_next = sat32(sum41);
                        end
                        busy_next  = 1'b0;
                        mstep_next = 2'd0;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            zden_reg  <= 1'b0;
            mstep_reg <= 2'd0;
            cnt_reg   <= '0;
            op_reg    <= DOP_NONE;
        end else begin
            busy_reg  <= busy_next;
            zden_reg  <= zden_next;
            mstep_reg <= mstep_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
        end
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign sts.busy     = busy_reg;
    assign sts.zero_den = zden_reg;
    assign result       = res_reg;

endmodule

// ----- hdl/ndd_ctrl.sv -----
// ============================================================================
// ndd_ctrl: sequencer of the interpolator
// Loads points, walks the divided-difference triangle, then evaluates the
// Newton form order by order and hands results to the output register.
// ============================================================================
module ndd_ctrl
    import ndd_pkg::*;
#(
    parameter int unsigned MAX_POINTS = NDD_MAX_POINTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_fire,
    input  logic                          in_last,
    input  logic signed [31:0]            in_query,
    output logic                          in_ready,
    // store access
    output logic                          x_we,
    output logic                          d_we,
    output logic [$clog2(MAX_POINTS)-1:0] waddr,
    output logic                          wsel_dp,
    output logic [$clog2(MAX_POINTS)-1:0] x_raddr,
    output logic [$clog2(MAX_POINTS)-1:0] d_raddr,
    input  logic signed [31:0]            x_rdata,
    input  logic signed [31:0]            d_rdata,
    // datapath
    output dp_cmd_t                       cmd,
    output logic signed [31:0]            opa_hi,
    output logic signed [31:0]            opa_lo,
    output logic signed [31:0]            opb_hi,
    output logic signed [31:0]            opb_lo,
    input  dp_sts_t                       sts,
    input  logic signed [31:0]            dp_result,
    // result register
    output logic                          out_load,
    output logic [3:0]                    out_order,
    output logic signed [31:0]            out_est,
    output logic signed [31:0]            out_change,
    output logic                          out_error,
    output logic                          out_last,
    input  logic                          out_free
);

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [10:0] {
        ST_LOAD  = 11'b00000000001,
        ST_DRD   = 11'b00000000010,
        ST_DRD2  = 11'b00000000100,
        ST_DGO   = 11'b00000001000,
        ST_DWAIT = 11'b00000010000,
        ST_ERD   = 11'b00000100000,
        ST_ERD2  = 11'b00001000000,
        ST_XGO   = 11'b00010000000,
        ST_XWAIT = 11'b00100000000,
        ST_TGO   = 11'b01000000000,
        ST_EMIT  = 11'b10000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [CW-1:0]      i_reg, i_next;
    logic               err_reg, err_next;
    logic signed [31:0] q_reg, q_next;
    logic signed [31:0] xt_reg, xt_next;
    logic signed [31:0] est_reg, est_next;
    logic signed [31:0] prev_reg, prev_next;
    logic signed [31:0] hi_reg, hi_next;   // d[i] first read
    logic signed [31:0] xa_reg, xa_next;   // x[i-1] during eval

    logic [CW-1:0] emit;
    assign emit = (32'(n_reg) < RESULT_LIMIT) ? n_reg : CW'(RESULT_LIMIT);

    assign in_ready = (state_reg == ST_LOAD);
    assign x_we     = in_fire && (cnt_reg < CW'(MAX_POINTS));
    assign waddr    = wsel_dp ? i_reg[AW-1:0] : cnt_reg[AW-1:0];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        err_next   = err_reg;
        q_next     = q_reg;
        xt_next    = xt_reg;
        est_next   = est_reg;
        prev_next  = prev_reg;
        hi_next    = hi_reg;
        xa_next    = xa_reg;
        d_we       = x_we;
        wsel_dp    = 1'b0;
        x_raddr    = i_reg[AW-1:0];
        d_raddr    = i_reg[AW-1:0];
        cmd.start  = 1'b0;
        cmd.op     = DOP_NONE;
        opa_hi     = d_rdata;
        opa_lo     = d_rdata;
        opb_hi     = x_rdata;
        opb_lo     = x_rdata;
        out_load   = 1'b0;
        out_order  = 4'(i_reg);
        out_est    = est_reg;
        out_change = est_reg - prev_reg;
        out_error  = err_reg;
        out_last   = (i_reg + CW'(1)) == emit;
        case (state_reg)
            ST_LOAD: begin
                if (in_fire) begin
                    if (cnt_reg < CW'(MAX_POINTS)) begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (in_last) begin
                        q_next   = in_query;
                        n_next   = (cnt_reg < CW'(MAX_POINTS)) ? cnt_reg + CW'(1)
                                                                : cnt_reg;
                        cnt_next = '0;
                        err_next = 1'b0;
                        j_next   = CW'(1);
                        i_next   = n_next - CW'(1);
                        state_next = (n_next > CW'(1)) ? ST_DRD : ST_ERD;
                        if (n_next <= CW'(1)) begin
                            i_next = '0;
                        end
                    end
                end
            end
            ST_DRD: begin
                // read d[i], x[i]
                state_next = ST_DRD2;
            end
            ST_DRD2: begin
                hi_next = d_rdata;
                xa_next = x_rdata;
                d_raddr = AW'(i_reg - CW'(1));
                x_raddr = AW'(i_reg - j_reg);
                state_next = ST_DGO;
            end
            ST_DGO: begin
                d_raddr   = AW'(i_reg - CW'(1));
                x_raddr   = AW'(i_reg - j_reg);
                opa_hi    = hi_reg;
                opa_lo    = d_rdata;
                opb_hi    = xa_reg;
                opb_lo    = x_rdata;
                cmd.start = 1'b1;
                cmd.op    = DOP_DIV;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (!sts.busy) begin
                    if (sts.zero_den) begin
                        err_next = 1'b1;
                    end
                    d_we    = 1'b1;
                    wsel_dp = 1'b1;
                    if (i_reg == j_reg) begin
                        if (j_reg + CW'(1) == n_reg) begin
                            i_next = '0;
                            state_next = ST_ERD;
                        end else begin
                            j_next = j_reg + CW'(1);
                            i_next = n_reg - CW'(1);
                            state_next = ST_DRD;
                        end
                    end else begin
                        i_next = i_reg - CW'(1);
                        state_next = ST_DRD;
                    end
                end
            end
            ST_ERD: begin
                // read d[i] and x[i-1]
                x_raddr = AW'(i_reg - CW'(1));
                state_next = ST_ERD2;
            end
            ST_ERD2: begin
                x_raddr = AW'(i_reg - CW'(1));
                hi_next = d_rdata;
                xa_next = x_rdata;
                if (i_reg == '0) begin
                    xt_next   = Q_ONE;
                    est_next  = d_rdata;
                    prev_next = d_rdata;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_XGO;
                end
            end
            ST_XGO: begin
                opa_hi    = xt_reg;
                opa_lo    = q_reg;
                opb_hi    = xa_reg;
                cmd.start = 1'b1;
                cmd.op    = DOP_XTERM;
                state_next = ST_XWAIT;
            end
            ST_XWAIT: begin
                opa_hi = xt_reg;
                opa_lo = q_reg;
                opb_hi = xa_reg;
                if (!sts.busy) begin
                    xt_next    = dp_result;
                    state_next = ST_TGO;
                end
            end
            ST_TGO: begin
                opa_hi = xt_reg;
                opb_hi = prev_reg;
                opb_lo = hi_reg;
                if (!sts.busy && j_reg == '0) begin
                    cmd.start = 1'b1;
                    cmd.op    = DOP_TERM;
                    j_next    = CW'(1);
                end else if (!sts.busy) begin
                    est_next   = dp_result;
                    j_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                out_change = (i_reg == '0) ? 32'sd0
                             : sat32(41'(est_reg) - 41'(prev_reg));
                if (out_free) begin
                    out_load  = 1'b1;
                    prev_next = est_reg;
                    j_next    = '0;
                    if (out_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        i_next     = i_reg + CW'(1);
                        state_next = ST_ERD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            n_reg     <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
            err_reg   <= 1'b0;
            q_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            j_reg     <= (state_next == ST_ERD && state_reg != ST_EMIT) ? '0 : j_next;
            i_reg     <= i_next;
            err_reg   <= err_next;
            q_reg     <= q_next;
        end
        xt_reg   <= xt_next;
        est_reg  <= est_next;
        prev_reg <= prev_next;
        hi_reg   <= hi_next;
        xa_reg   <= xa_next;
    end

`ifndef SYNTHESIS
    a_ready_only_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> state_reg == ST_LOAD)
        else $error("input ready outside load");
    a_no_cmd_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> sts.busy || sts.zero_den)
        else $error("command lost");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count overflow");
`endif

endmodule

// ----- hdl/newton_divided_difference_interp.sv -----
// Work: N stored points need N(N-1)/2 serial divisions, plus an xterm and a
// term multiply for each result order above zero during evaluation.
// Throughput: one run at a time; points load at one per cycle while idle.
// The 49-step restoring divider in the datapath sets the rate.
// Reset: aresetn synchronous, active low; clears control, store contents stay
// undefined until written.
// ============================================================================
// newton_divided_difference_interp: Newton divided-difference interpolator
// Loads Q16.16 points, builds the coefficient triangle in place and streams
// one estimate per interpolation order.
// ============================================================================
module newton_divided_difference_interp
    import ndd_pkg::*;
#(
    parameter int unsigned MAX_POINTS = NDD_MAX_POINTS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // x_value[31:0], y_value[63:32], query_point[95:64]
    input  logic         s_tlast,   // last_point
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // order[3:0], estimate[35:4], change[67:36], zero pad
    output logic         m_tuser,   // error
    output logic         m_tlast    // last_result
);

    localparam int unsigned AW = $clog2(MAX_POINTS);

    logic                 in_fire;
    logic                 x_we, d_we, wsel_dp;
    logic [AW-1:0]        waddr, x_raddr, d_raddr;
    logic signed [31:0]   x_rdata, d_rdata, d_wdata, dp_result;
    logic signed [31:0]   opa_hi, opa_lo, opb_hi, opb_lo;
    dp_cmd_t              cmd;
    dp_sts_t              sts;
    logic                 out_load, out_error, out_last;
    logic [3:0]           out_order;
    logic signed [31:0]   out_est, out_change;
    logic                 ov_reg, ov_next;
    logic [71:0]          od_reg;
    logic                 oe_reg, ol_reg;

    assign in_fire = s_tvalid && s_tready;
    // d store write data: datapath result while building the triangle, else the point's y value
    assign d_wdata = wsel_dp ? dp_result : s_tdata[63:32];

    ndd_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_xram (
        .aclk(aclk), .we(x_we), .waddr(waddr), .wdata(s_tdata[31:0]),
        .raddr(x_raddr), .rdata(x_rdata));

    ndd_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_dram (
        .aclk(aclk), .we(d_we), .waddr(waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata));

    ndd_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_last(s_tlast),
        .in_query(s_tdata[95:64]), .in_ready(s_tready),
        .x_we(x_we), .d_we(d_we), .waddr(waddr), .wsel_dp(wsel_dp),
        .x_raddr(x_raddr), .d_raddr(d_raddr), .x_rdata(x_rdata), .d_rdata(d_rdata),
        .cmd(cmd), .opa_hi(opa_hi), .opa_lo(opa_lo), .opb_hi(opb_hi),
        .opb_lo(opb_lo), .sts(sts), .dp_result(dp_result),
        .out_load(out_load), .out_order(out_order), .out_est(out_est),
        .out_change(out_change), .out_error(out_error), .out_last(out_last),
        .out_free(!ov_reg || m_tready));

    ndd_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .opa_hi(opa_hi),
        .opa_lo(opa_lo), .opb_hi(opb_hi), .opb_lo(opb_lo), .sts(sts),
        .result(dp_result));

    // advance the output register on load, drop valid when the transfer ends
    always_comb begin
        ov_next = ov_reg;
        if (out_load) begin
            ov_next = 1'b1;
        end else if (m_tready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else begin
            ov_reg <= ov_next;
        end
        if (out_load) begin
            od_reg <= {4'd0, out_change, out_est, out_order};
            oe_reg <= out_error;
            ol_reg <= out_last;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = oe_reg;
    assign m_tlast  = ol_reg;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the Newton divided-difference interpolator
// Streams runs of Q16.16 points with random gaps and stalls, predicts every
// per-order estimate in the bench and compares each result transfer in order.
// ============================================================================
module tb_top;
    import ndd_pkg::*;

    localparam int NPTS      = NDD_MAX_POINTS;
    localparam int WDOG_MAX  = 40000;

    typedef struct packed {
        logic signed [31:0] xv;
        logic signed [31:0] yv;
        logic signed [31:0] qv;
        logic               lastp;
    } point_t;

    typedef struct packed {
        logic [3:0]         ord;
        logic signed [31:0] est;
        logic signed [31:0] chg;
        logic               err;
        logic               lastr;
    } estimate_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;   // x_value, y_value, query_point
    logic        s_tlast = 1'b0; // last_point
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // order, estimate, change, pad
    logic        m_tuser;        // error
    logic        m_tlast;        // last_result

    newton_divided_difference_interp dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predictor state: mirror of the block's point store.
    logic signed [31:0] xs [NPTS];
    logic signed [31:0] ds [NPTS];
    int                 npts_held;

    point_t    pending_points[$];
    estimate_t expected_estimates[$];
    int        fails = 0;

    function automatic logic [63:0] magn(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sh7fffffff) return 32'sh7fffffff;
        if (v < -64'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] apply_sign(input logic [63:0] m, input logic neg);
        logic signed [63:0] s;
        if (m > 64'd1 << 40) m = 64'd1 << 40;
        s = neg ? -$signed(m) : $signed(m);
        return clip32(s);
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic [63:0] p;
        p = (magn(a) * magn(b) + 64'd32768) >> 16;
        return apply_sign(p, (a < 0) != (b < 0));
    endfunction

    function automatic logic signed [31:0] qdiv(input logic signed [63:0] n,
                                                input logic signed [63:0] d);
        logic [63:0] un, ud, q;
        un = magn(n);
        ud = magn(d);
        q = ((un << 16) + ud / 2) / ud;
        return apply_sign(q, (n < 0) != (d < 0));
    endfunction

    // Store one accepted point; on the closing point build the coefficient
    // triangle and queue one estimate per order.
    task automatic interpolate_point(input point_t p);
        int n, emit;
        logic err;
        logic signed [31:0] xterm, est, prev, chg;
        logic signed [63:0] num, den;
        estimate_t e;
        err = 1'b0;
        if (npts_held < NPTS) begin
            xs[npts_held] = p.xv;
            ds[npts_held] = p.yv;
            npts_held++;
        end
        if (!p.lastp) return;
        n = npts_held;
        npts_held = 0;
        for (int j = 1; j < n; j++) begin
            for (int i = n - 1; i >= j; i--) begin
                num = 64'(ds[i]) - 64'(ds[i-1]);
                den = 64'(xs[i]) - 64'(xs[i-j]);
                if (den == 0) begin
                    err = 1'b1;
                    ds[i] = '0;
                end else begin
                    ds[i] = qdiv(num, den);
                end
            end
        end
        emit = n < RESULT_LIMIT ? n : RESULT_LIMIT;
        xterm = Q_ONE;
        est = ds[0];
        prev = est;
        for (int i = 0; i < emit; i++) begin
            chg = '0;
            if (i > 0) begin
                xterm = qmul(xterm, clip32(64'(p.qv) - 64'(xs[i-1])));
                est = clip32(64'(prev) + 64'(qmul(ds[i], xterm)));
                chg = clip32(64'(est) - 64'(prev));
                prev = est;
            end
            e.ord = i[3:0];
            e.est = est;
            e.chg = chg;
            e.err = err;
            e.lastr = (i + 1 == emit);
            expected_estimates = {expected_estimates, e};
        end
    endtask

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            2: return $signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000;
            default: return $signed($urandom_range(0, 32'h00600000)) - 32'sh00300000;
        endcase
    endfunction

    task automatic add_point(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] q, input logic lp);
        point_t p;
        p.xv = x;
        p.yv = y;
        p.qv = q;
        p.lastp = lp;
        pending_points = {pending_points, p};
    endtask

    // Queue n points, mostly on a stepped x grid; dup makes the last x repeat.
    task automatic add_run(input int n, input logic dup);
        logic signed [31:0] base, step;
        base = $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
        step = $signed($urandom_range(32'h00001000, 32'h00030000));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                add_point(rand_q(), rand_q(), rand_q(), i == n - 1);
            end else begin
                add_point(base + i * step + (dup && i == n - 1 ? -step : 0),
                          rand_q(), base + $signed($urandom_range(0, 32'h00100000)),
                          i == n - 1);
            end
        end
    endtask

    initial begin
        // Directed: single point, extremes, duplicate abscissae, store overflow.
        add_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1);
        add_point(32'sh80000000, 32'sh7fffffff, 32'sh00000000, 1'b0);
        add_point(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1'b1);
        add_point(32'sh00010000, 32'sh00020000, 32'sh00018000, 1'b0);
        add_point(32'sh00010000, 32'sh00050000, 32'shffffffff, 1'b1);
        for (int i = 0; i < 18; i++) begin
            add_point(i << 16, (i * i) << 16, 32'sh00028000, i == 17);
        end
        while (pending_points.size() < 270) begin
            case ($urandom_range(0, 9))
                0:       add_run(NPTS + $urandom_range(0, 2), 1'b0);
                1:       add_run($urandom_range(2, 6), 1'b1);
                default: add_run($urandom_range(1, 6), 1'b0);
            endcase
        end
    end

    // Driver: pop pending points, wait a random gap before each transfer.
    int gap_left = 0;
    always @(posedge aclk) begin
        int gap;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                interpolate_point(pending_points.pop_front());
                gap = $urandom_range(0, 7);
                if (gap != 0 || pending_points.size() == 0) begin
                    gap_left <= gap - 1;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tdata <= {pending_points[0].qv, pending_points[0].yv,
                                pending_points[0].xv};
                    s_tlast <= pending_points[0].lastp;
                end
            end else if (!s_tvalid && pending_points.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {pending_points[0].qv, pending_points[0].yv,
                                pending_points[0].xv};
                    s_tlast <= pending_points[0].lastp;
                end
            end
        end
    end

    // Monitor: random backpressure, compare each result with the oldest estimate.
    int stall_left = 0;
    always @(posedge aclk) begin
        estimate_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_estimates.size() == 0) begin
                    $error("unexpected result transfer, tdata=%h", m_tdata);
                    fails++;
                end else begin
                    e = expected_estimates.pop_front();
                    if (m_tdata[3:0] !== e.ord) begin
                        $error("order exp %0d got %0d", e.ord, m_tdata[3:0]);
                        fails++;
                    end
                    if (m_tdata[35:4] !== e.est) begin
                        $error("estimate exp %h got %h", e.est, m_tdata[35:4]);
                        fails++;
                    end
                    if (m_tdata[67:36] !== e.chg) begin
                        $error("change exp %h got %h", e.chg, m_tdata[67:36]);
                        fails++;
                    end
                    if (m_tuser !== e.err) begin
                        $error("error exp %b got %b", e.err, m_tuser);
                        fails++;
                    end
                    if (m_tlast !== e.lastr) begin
                        $error("last_result exp %b got %b", e.lastr, m_tlast);
                        fails++;
                    end
                end
                stall_left = $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0) stall_left = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_MAX) begin
            $display("FAIL newton_divided_difference_interp");
            $finish;
        end
    end

    initial begin
        npts_held = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_points.size() == 0 && !s_tvalid);
        wait (expected_estimates.size() == 0);
        repeat (200) @(posedge aclk);
        if (fails == 0 && expected_estimates.size() == 0) begin
            $display("PASS newton_divided_difference_interp");
        end else begin
            $display("FAIL newton_divided_difference_interp");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ndd_pkg.sv
hdl/ndd_ram.sv
hdl/ndd_datapath.sv
hdl/ndd_ctrl.sv
hdl/newton_divided_difference_interp.sv
tb/tb_top.sv
